// File: rtl/tols_pkg.sv
`default_nettype none

package tols_pkg;

	// Number of defined type tags; a tag at or above this is a format error.
	localparam int unsigned TagCount = 24;
	localparam logic [15:0] CountLimitReset = 16'd1000;

	// Position in the current object.
	typedef enum logic [1:0] {
		PH_TAG,
		PH_HEADER,
		PH_FLAG,
		PH_PAYLOAD
	} phase_t;

	// How a tag's payload is laid out.
	typedef enum logic [2:0] {
		KIND_FIXED,
		KIND_U16,
		KIND_U8,
		KIND_U32,
		KIND_STR
	} kind_t;

	// Outcome of one byte.
	typedef enum logic [1:0] {
		GO_ON,
		GO_OK,
		GO_ERR
	} go_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] unit;
	} tag_info_t;

	// Payload layout of each tag. The unit is the fixed payload size for fixed
	// tags and the bytes per counted element otherwise.
	function automatic tag_info_t tag_info(input logic [4:0] tag);
		tag_info_t info;
		case (tag)
			5'd0:    info = '{KIND_FIXED, 4'd0};
			5'd1:    info = '{KIND_FIXED, 4'd4};
			5'd2:    info = '{KIND_FIXED, 4'd8};
			5'd3:    info = '{KIND_FIXED, 4'd4};
			5'd4:    info = '{KIND_STR,   4'd1};
			5'd5:    info = '{KIND_FIXED, 4'd3};
			5'd6:    info = '{KIND_U16,   4'd4};
			5'd7:    info = '{KIND_FIXED, 4'd8};
			5'd8:    info = '{KIND_U8,    4'd4};
			5'd9:    info = '{KIND_FIXED, 4'd3};
			5'd10:   info = '{KIND_FIXED, 4'd1};
			5'd11:   info = '{KIND_FIXED, 4'd8};
			5'd12:   info = '{KIND_FIXED, 4'd4};
			5'd13:   info = '{KIND_FIXED, 4'd2};
			5'd14:   info = '{KIND_U32,   4'd1};
			5'd15:   info = '{KIND_FIXED, 4'd1};
			5'd16:   info = '{KIND_U32,   4'd1};
			5'd17:   info = '{KIND_FIXED, 4'd4};
			5'd18:   info = '{KIND_U16,   4'd8};
			5'd19:   info = '{KIND_FIXED, 4'd8};
			5'd20:   info = '{KIND_FIXED, 4'd1};
			5'd21:   info = '{KIND_U16,   4'd4};
			5'd22:   info = '{KIND_U32,   4'd0};
			5'd23:   info = '{KIND_FIXED, 4'd2};
			default: info = '{KIND_FIXED, 4'd0};
		endcase
		return info;
	endfunction

	// Tag that opens an array of nested objects.
	localparam logic [4:0] TagArray = 5'd22;

endpackage

`default_nettype wire

// File: rtl/tagged_object_length_scanner.sv
// Byte-wise length scanner for tagged binary objects.
//
// Bytes enter on the input channel (in_valid/in_ready, data_byte, last_byte),
// one beat per byte. Each byte either continues the current object or ends
// it; an ending byte produces one beat on the output channel (out_valid/
// out_ready, status, object_length): status 0 with the byte count of the
// object, tag included, or status 1 with length 0 on a format error. After
// any result the next byte is read as a new tag.
//
// A byte accepted into the input register is processed once it can move into
// the result register; the result is registered there. One byte is taken
// every cycle while the result register is free or drains; the open-array
// stack is resolved by a single priority encode over the open levels, so
// nested arrays that all end on the same byte close together in that cycle.
//
// When the receiver stalls, the result is held and one more byte is buffered
// in the input register, after which in_ready drops. Reset clears the walk and
// sets count_limit to 1000; no clearing pass is needed. The user must write
// count_limit via cfg_we/cfg_wdata only while the block is idle (not enforced).

`default_nettype none

module tagged_object_length_scanner
	import tols_pkg::*;
#(
	parameter int MAX_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             status,
	output logic [31:0]      object_length,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	localparam int LP_W = $clog2(MAX_DEPTH + 1);

	// Input register.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	// Walk state.
	phase_t      phase_q;
	logic [4:0]  tag_q;
	logic [31:0] shift_q;
	logic [2:0]  hleft_q;
	logic [19:0] pleft_q;
	logic [LP_W-1:0] lp_q;
	logic [31:0] total_q;
	logic [15:0] count_limit_q;
	logic [15:0] level_counts_q [MAX_DEPTH];

	// Result register.
	logic        out_valid_q;
	logic        status_q;
	logic [31:0] length_q;

	logic advance;
	logic step;

	// The input stage moves on whenever the result register is free or drains.
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Find the innermost open level that stays open after a decrement.
	logic            keep_found;
	logic [LP_W-1:0] keep_sel;

	always_comb begin
		keep_found = 1'b0;
		keep_sel   = '0;
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (LP_W'(i) < lp_q && level_counts_q[i] != 16'd1) begin
				keep_found = 1'b1;
				keep_sel   = LP_W'(i);
			end
		end
	end

	// Next walk state for the byte in the input register.
	phase_t      phase_n;
	logic [4:0]  tag_n;
	logic [31:0] shift_n;
	logic [2:0]  hleft_n;
	logic [19:0] pleft_n;
	logic [LP_W-1:0] lp_n;
	logic [31:0] total_n;
	go_t         go;
	logic        do_close;
	logic        do_open;
	logic        dec_we;
	logic [15:0] open_n;
	logic [19:0] pay_len;
	logic        pay_start;
	tag_info_t   info_b;
	tag_info_t   info_q;
	logic [31:0] hdr_val;
	logic        hdr_done;

	always_comb begin
		phase_n   = phase_q;
		tag_n     = tag_q;
		shift_n   = shift_q;
		hleft_n   = hleft_q;
		pleft_n   = pleft_q;
		lp_n      = lp_q;
		total_n   = (total_q == 32'hFFFF_FFFF) ? total_q : total_q + 32'd1;
		go        = GO_ON;
		do_close  = 1'b0;
		do_open   = 1'b0;
		dec_we    = 1'b0;
		open_n    = '0;
		pay_len   = '0;
		pay_start = 1'b0;
		info_b    = tag_info(data_s1[4:0]);
		info_q    = tag_info(tag_q);
		hdr_val   = {shift_q[23:0], data_s1};
		hdr_done  = 1'b0;

		case (phase_q)
			PH_TAG: begin
				if (data_s1 >= 8'(TagCount)) begin
					go = GO_ERR;
				end else begin
					tag_n   = data_s1[4:0];
					shift_n = '0;
					case (info_b.kind)
						KIND_FIXED: begin
							pay_start = 1'b1;
							pay_len   = 20'(info_b.unit);
						end
						KIND_STR: phase_n = PH_FLAG;
						KIND_U8: begin
							hleft_n = 3'd1;
							phase_n = PH_HEADER;
						end
						KIND_U16: begin
							hleft_n = 3'd2;
							phase_n = PH_HEADER;
						end
						default: begin
							hleft_n = 3'd4;
							phase_n = PH_HEADER;
						end
					endcase
				end
			end
			PH_FLAG: begin
				if (data_s1 == 8'd0) begin
					do_close = 1'b1;
				end else begin
					shift_n = '0;
					hleft_n = 3'd2;
					phase_n = PH_HEADER;
				end
			end
			PH_HEADER: begin
				shift_n = hdr_val;
				if (hleft_q != 3'd0) begin
					hleft_n = hleft_q - 3'd1;
				end
				hdr_done = (hleft_n == 3'd0);
			end
			PH_PAYLOAD: begin
				if (pleft_q != 20'd0) begin
					pleft_n = pleft_q - 20'd1;
				end
				do_close = (pleft_n == 20'd0);
			end
			default: go = GO_ERR;
		endcase

		// Count complete: limit-check U16/U32, then open an array or a payload.
		if (hdr_done) begin
			if ((info_q.kind == KIND_U16 || info_q.kind == KIND_U32)
					&& hdr_val > {16'd0, count_limit_q}) begin
				go = GO_ERR;
			end else if (tag_q == TagArray) begin
				if (hdr_val == 32'd0) begin
					do_close = 1'b1;
				end else if (lp_q >= LP_W'(MAX_DEPTH)) begin
					go = GO_ERR;
				end else begin
					do_open = 1'b1;
					open_n  = hdr_val[15:0];
					lp_n    = lp_q + LP_W'(1);
					phase_n = PH_TAG;
				end
			end else begin
				pay_start = 1'b1;
				case (info_q.unit)
					4'd4:    pay_len = {2'b00, hdr_val[15:0], 2'b00};
					4'd8:    pay_len = {1'b0, hdr_val[15:0], 3'b000};
					default: pay_len = {4'd0, hdr_val[15:0]};
				endcase
			end
		end

		// Empty payload ends the object at once.
		if (pay_start) begin
			if (pay_len == 20'd0) begin
				do_close = 1'b1;
			end else begin
				pleft_n = pay_len;
				phase_n = PH_PAYLOAD;
			end
		end

		// Object ended: close every array whose last element it was.
		if (do_close) begin
			phase_n = PH_TAG;
			if (keep_found) begin
				dec_we = 1'b1;
				lp_n   = keep_sel + LP_W'(1);
			end else begin
				go = GO_OK;
			end
		end

		if (go == GO_ON && last_s1) begin
			go = GO_ERR;
		end
	end

	logic res_load;
	assign res_load = step && (go != GO_ON);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			tag_q         <= '0;
			shift_q       <= '0;
			hleft_q       <= '0;
			pleft_q       <= '0;
			lp_q          <= '0;
			total_q       <= '0;
			count_limit_q <= CountLimitReset;
		end else begin
			if (cfg_we) begin
				count_limit_q <= cfg_wdata;
			end
			if (res_load) begin
				phase_q <= PH_TAG;
				tag_q   <= '0;
				shift_q <= '0;
				hleft_q <= '0;
				pleft_q <= '0;
				lp_q    <= '0;
				total_q <= '0;
			end else if (step) begin
				phase_q <= phase_n;
				tag_q   <= tag_n;
				shift_q <= shift_n;
				hleft_q <= hleft_n;
				pleft_q <= pleft_n;
				lp_q    <= lp_n;
				total_q <= total_n;
			end
		end
	end

	// Stack of remaining element counts; each entry updates in place.
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (step && !res_load) begin
				if (do_open && lp_q == LP_W'(i)) begin
					level_counts_q[i] <= open_n;
				end else if (dec_we && keep_sel == LP_W'(i)) begin
					level_counts_q[i] <= level_counts_q[i] - 16'd1;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= (go == GO_ERR);
			length_q <= (go == GO_ERR) ? 32'd0 : total_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign object_length = length_q;

	// The stack never grows past its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		lp_q <= LP_W'(MAX_DEPTH))
		else $error("level pointer beyond stack depth");

	// An error result carries no length.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q |-> length_q == 32'd0)
		else $error("error result with nonzero length");

	// Every result restarts the walk at a tag with no open array.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> phase_q == PH_TAG && lp_q == '0 && total_q == 32'd0)
		else $error("walk not cleared after result");

	// A payload phase always has bytes left to consume.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pleft_q != 20'd0)
		else $error("payload phase with nothing left");

	// A stalled result keeps the input stage from moving.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !step)
		else $error("byte processed while result stalled");

endmodule

`default_nettype wire
